### rtl/core/tmarb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmarb_pkg
// Shared types and constants of the two-way transmit merge arbiter.
// ----------------------------------------------------------------------------
package tmarb_pkg;

   // Bytes carried by one data word (8 to 64).
   localparam int unsigned WORD_BYTES = 64;
   localparam int unsigned KEEP_W     = 64;
   localparam int unsigned SESS_W     = 16;
   localparam int unsigned LEN_W      = 16;

   // Depth of the queue between front and back.
   localparam int unsigned QDEPTH  = 2;
   localparam int unsigned QPTR_W  = $clog2(QDEPTH);
   localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

   localparam logic [LEN_W-1:0] WORD_BYTES_L = LEN_W'(WORD_BYTES);

   // Bit positions in lost_flags and words_present.
   localparam int unsigned LOST_CLIENT_BIT = 0;
   localparam int unsigned LOST_SERVER_BIT = 1;
   localparam int unsigned WORD_DOWN_BIT   = 0;
   localparam int unsigned WORD_UP_BIT     = 1;

   // Pop codes on len_taken / word_taken.
   localparam logic [1:0] TAKE_NONE = 2'd0;
   localparam logic [1:0] TAKE_DOWN = 2'd1;
   localparam logic [1:0] TAKE_UP   = 2'd2;

   typedef enum logic [1:0] {
      ST_NONE     = 2'd0,
      ST_ACCEPTED = 2'd1,
      ST_CLOSED   = 2'd2,
      ST_NO_SPACE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PH_SELECT  = 2'd0,
      PH_WAIT    = 2'd1,
      PH_WRITE   = 2'd2,
      PH_DISCARD = 2'd3
   } phase_type;

   // One classified request, as held in the queue.
   typedef struct packed {
      logic              srv_present;
      logic [SESS_W-1:0] srv_session;
      logic              cli_present;
      logic [SESS_W-1:0] cli_session;
      logic              cli_lost;
      logic              srv_lost;
      logic              cli_pend;
      logic [LEN_W-1:0]  cli_len;
      logic              srv_pend;
      logic [LEN_W-1:0]  srv_len;
      logic              down_word;
      logic              up_word;
      status_type        status;
   } item_type;

   // Queue head handed from front to back.
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

endpackage
`default_nettype wire

### rtl/core/tmarb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmarb_front
// Accepts requests, splits them into flags and fields, and queues them.
// ----------------------------------------------------------------------------
module tmarb_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_server_session_present,
   input  wire logic [tmarb_pkg::SESS_W-1:0] req_server_session,
   input  wire logic                         req_client_session_present,
   input  wire logic [tmarb_pkg::SESS_W-1:0] req_client_session,
   input  wire logic [1:0]                   req_lost_flags,
   input  wire logic                         req_client_len_present,
   input  wire logic [tmarb_pkg::LEN_W-1:0]  req_client_len,
   input  wire logic                         req_server_len_present,
   input  wire logic [tmarb_pkg::LEN_W-1:0]  req_server_len,
   input  wire logic [1:0]                   req_words_present,
   input  wire logic [1:0]                   req_status_code,
   output tmarb_pkg::head_type               head,
   input  wire logic                         pop
);
   import tmarb_pkg::*;

   item_type            q_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   item_type            cls;
   logic                push;
   logic                do_pop;

   always_comb begin
      cls.srv_present = req_server_session_present;
      cls.srv_session = req_server_session;
      cls.cli_present = req_client_session_present;
      cls.cli_session = req_client_session;
      cls.cli_lost    = req_lost_flags[LOST_CLIENT_BIT];
      cls.srv_lost    = req_lost_flags[LOST_SERVER_BIT];
      cls.cli_pend    = req_client_len_present;
      cls.cli_len     = req_client_len;
      cls.srv_pend    = req_server_len_present;
      cls.srv_len     = req_server_len;
      cls.down_word   = req_words_present[WORD_DOWN_BIT];
      cls.up_word     = req_words_present[WORD_UP_BIT];
      cls.status      = status_type'(req_status_code);
   end

   assign req_stall  = (count_ff == QCNT_W'(QDEPTH));
   assign push       = req_valid && !req_stall;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.item  = q_ff[rd_ptr_ff];

   // pointers wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QDEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QDEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule
`default_nettype wire

### rtl/core/tmarb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmarb_back
// Session tracking, direction arbiter, transmit state machine and the
// registered response stage.
// ----------------------------------------------------------------------------
module tmarb_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire tmarb_pkg::head_type          head,
   output logic                              pop,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [1:0]                        rsp_len_taken,
   output logic [1:0]                        rsp_word_taken,
   output logic                              rsp_status_taken,
   output logic                              rsp_meta_valid,
   output logic [tmarb_pkg::SESS_W-1:0]      rsp_meta_session,
   output logic [tmarb_pkg::LEN_W-1:0]       rsp_meta_length,
   output logic                              rsp_word_forward,
   output logic [tmarb_pkg::KEEP_W-1:0]      rsp_word_keep,
   output logic                              rsp_word_last
);
   import tmarb_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [SESS_W-1:0] srv_id_ff, srv_id_in;
   logic [SESS_W-1:0] cli_id_ff, cli_id_in;
   logic              srv_live_ff, srv_live_in;
   logic              cli_live_ff, cli_live_in;
   logic              favor_cli_ff, favor_cli_in;
   logic              active_cli_ff, active_cli_in;
   logic [LEN_W-1:0]  chunk_len_ff, chunk_len_in;
   logic [LEN_W-1:0]  left_ff, left_in;

   logic              valid_ff, valid_in;
   logic [1:0]        len_taken_ff, len_taken_in;
   logic [1:0]        word_taken_ff, word_taken_in;
   logic              status_taken_ff, status_taken_in;
   logic              meta_valid_ff, meta_valid_in;
   logic [SESS_W-1:0] meta_session_ff, meta_session_in;
   logic [LEN_W-1:0]  meta_length_ff, meta_length_in;
   logic              word_forward_ff, word_forward_in;
   logic [KEEP_W-1:0] word_keep_ff, word_keep_in;
   logic              word_last_ff, word_last_in;

   item_type          it;
   logic [SESS_W-1:0] srv_id_u, cli_id_u;
   logic              srv_live_u, cli_live_u;
   logic              c_ok, s_ok, pick, drop, sel_cli;
   logic              word_here, chunk_end;
   logic [LEN_W-1:0]  sel_len, left_dec;

   assign it  = head.item;
   assign pop = head.valid && (!valid_ff || !rsp_stall);

   // session updates first, losses override
   always_comb begin
      srv_id_u   = it.srv_present ? it.srv_session : srv_id_ff;
      cli_id_u   = it.cli_present ? it.cli_session : cli_id_ff;
      srv_live_u = (srv_live_ff || it.srv_present) && !it.srv_lost;
      cli_live_u = (cli_live_ff || it.cli_present) && !it.cli_lost;
   end

   // round robin among live directions, dead ones drained downlink first
   always_comb begin
      c_ok = cli_live_u && it.cli_pend;
      s_ok = srv_live_u && it.srv_pend;
      pick = c_ok || s_ok;
      drop = !pick && ((it.cli_pend && !cli_live_u) || (it.srv_pend && !srv_live_u));
      if (pick) begin
         sel_cli = favor_cli_ff ? c_ok : !s_ok;
      end else begin
         sel_cli = it.cli_pend && !cli_live_u;
      end
      sel_len   = sel_cli ? it.cli_len : it.srv_len;
      word_here = active_cli_ff ? it.down_word : it.up_word;
      chunk_end = (left_ff <= WORD_BYTES_L);
      left_dec  = chunk_end ? '0 : left_ff - WORD_BYTES_L;
   end

   // next state
   always_comb begin
      phase_in      = phase_ff;
      srv_id_in     = srv_id_u;
      cli_id_in     = cli_id_u;
      srv_live_in   = srv_live_u;
      cli_live_in   = cli_live_u;
      favor_cli_in  = favor_cli_ff;
      active_cli_in = active_cli_ff;
      chunk_len_in  = chunk_len_ff;
      left_in       = left_ff;
      unique case (phase_ff)
         PH_SELECT: begin
            if (pick || drop) begin
               active_cli_in = sel_cli;
               chunk_len_in  = sel_len;
               left_in       = sel_len;
               phase_in      = pick ? PH_WAIT : PH_DISCARD;
            end
         end
         PH_WAIT: begin
            unique case (it.status)
               ST_ACCEPTED: phase_in = PH_WRITE;
               ST_CLOSED: begin
                  if (active_cli_ff) begin
                     cli_live_in = 1'b0;
                  end else begin
                     srv_live_in = 1'b0;
                  end
                  phase_in = PH_DISCARD;
               end
               ST_NONE, ST_NO_SPACE: phase_in = PH_WAIT;
            endcase
         end
         PH_WRITE, PH_DISCARD: begin
            if (word_here) begin
               left_in = left_dec;
               if (chunk_end) begin
                  favor_cli_in = !favor_cli_ff;
                  phase_in     = PH_SELECT;
               end
            end
         end
      endcase
   end

   // response fields
   always_comb begin
      len_taken_in    = TAKE_NONE;
      word_taken_in   = TAKE_NONE;
      status_taken_in = 1'b0;
      meta_valid_in   = 1'b0;
      meta_session_in = '0;
      meta_length_in  = '0;
      word_forward_in = 1'b0;
      word_keep_in    = '0;
      word_last_in    = 1'b0;
      unique case (phase_ff)
         PH_SELECT: begin
            if (pick || drop) begin
               len_taken_in = sel_cli ? TAKE_DOWN : TAKE_UP;
            end
            if (pick) begin
               meta_valid_in   = 1'b1;
               meta_session_in = sel_cli ? cli_id_u : srv_id_u;
               meta_length_in  = sel_len;
            end
         end
         PH_WAIT: begin
            status_taken_in = (it.status != ST_NONE);
            if (it.status == ST_NO_SPACE) begin
               meta_valid_in   = 1'b1;
               meta_session_in = active_cli_ff ? cli_id_u : srv_id_u;
               meta_length_in  = chunk_len_ff;
            end
         end
         PH_WRITE: begin
            if (word_here) begin
               word_taken_in   = active_cli_ff ? TAKE_DOWN : TAKE_UP;
               word_forward_in = 1'b1;
               word_last_in    = chunk_end;
               for (int i = 0; i < KEEP_W; i++) begin
                  word_keep_in[i] = (i < WORD_BYTES) && (left_ff > LEN_W'(i));
               end
            end
         end
         PH_DISCARD: begin
            if (word_here) begin
               word_taken_in = active_cli_ff ? TAKE_DOWN : TAKE_UP;
            end
         end
      endcase
   end

   assign valid_in = pop || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SELECT;
         srv_id_ff     <= '0;
         cli_id_ff     <= '0;
         srv_live_ff   <= 1'b0;
         cli_live_ff   <= 1'b0;
         favor_cli_ff  <= 1'b0;
         active_cli_ff <= 1'b0;
         chunk_len_ff  <= '0;
         left_ff       <= '0;
         valid_ff      <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            phase_ff      <= phase_in;
            srv_id_ff     <= srv_id_in;
            cli_id_ff     <= cli_id_in;
            srv_live_ff   <= srv_live_in;
            cli_live_ff   <= cli_live_in;
            favor_cli_ff  <= favor_cli_in;
            active_cli_ff <= active_cli_in;
            chunk_len_ff  <= chunk_len_in;
            left_ff       <= left_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         len_taken_ff    <= len_taken_in;
         word_taken_ff   <= word_taken_in;
         status_taken_ff <= status_taken_in;
         meta_valid_ff   <= meta_valid_in;
         meta_session_ff <= meta_session_in;
         meta_length_ff  <= meta_length_in;
         word_forward_ff <= word_forward_in;
         word_keep_ff    <= word_keep_in;
         word_last_ff    <= word_last_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_len_taken    = len_taken_ff;
   assign rsp_word_taken   = word_taken_ff;
   assign rsp_status_taken = status_taken_ff;
   assign rsp_meta_valid   = meta_valid_ff;
   assign rsp_meta_session = meta_session_ff;
   assign rsp_meta_length  = meta_length_ff;
   assign rsp_word_forward = word_forward_ff;
   assign rsp_word_keep    = word_keep_ff;
   assign rsp_word_last    = word_last_ff;

endmodule
`default_nettype wire

### rtl/core/two_way_tx_merge_arbiter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_way_tx_merge_arbiter
// One transmitter shared by the downlink and uplink relay directions.
// ----------------------------------------------------------------------------
// Each request is one tick of the upstream queue heads; each produces exactly
// one response. Requests are taken one per cycle while the queue has room; an
// accepted request is written into the queue, then popped by the back into
// the registered response stage that drives rsp_valid. A two-entry queue sits
// between the front (accept and decode) and the back (session tracking,
// round-robin direction select, meta / status wait / word write / discard
// machine, registered response). The back steps once per cycle whenever the
// response register is empty or being taken; req_stall rises only when the
// queue is full. The 512-bit data payload is not carried here: mux it outside
// with rsp_word_taken. rsp_word_keep has one bit per byte, set for the valid
// bytes of a forwarded word, and rsp_word_last marks the final word of a
// chunk. Fields not in use read as zero.
// ----------------------------------------------------------------------------
module two_way_tx_merge_arbiter (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request channel
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_server_session_present,
   input  wire logic [tmarb_pkg::SESS_W-1:0] req_server_session,
   input  wire logic                         req_client_session_present,
   input  wire logic [tmarb_pkg::SESS_W-1:0] req_client_session,
   input  wire logic [1:0]                   req_lost_flags,
   input  wire logic                         req_client_len_present,
   input  wire logic [tmarb_pkg::LEN_W-1:0]  req_client_len,
   input  wire logic                         req_server_len_present,
   input  wire logic [tmarb_pkg::LEN_W-1:0]  req_server_len,
   input  wire logic [1:0]                   req_words_present,
   input  wire logic [1:0]                   req_status_code,
   // response channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [1:0]                        rsp_len_taken,
   output logic [1:0]                        rsp_word_taken,
   output logic                              rsp_status_taken,
   output logic                              rsp_meta_valid,
   output logic [tmarb_pkg::SESS_W-1:0]      rsp_meta_session,
   output logic [tmarb_pkg::LEN_W-1:0]       rsp_meta_length,
   output logic                              rsp_word_forward,
   output logic [tmarb_pkg::KEEP_W-1:0]      rsp_word_keep,
   output logic                              rsp_word_last
);
   import tmarb_pkg::*;

   head_type head;   // queue head, front to back
   logic     pop;    // back consumes the head

   tmarb_front u_front (
      .clock                      (clock),
      .reset                      (reset),
      .req_valid                  (req_valid),
      .req_stall                  (req_stall),
      .req_server_session_present (req_server_session_present),
      .req_server_session         (req_server_session),
      .req_client_session_present (req_client_session_present),
      .req_client_session         (req_client_session),
      .req_lost_flags             (req_lost_flags),
      .req_client_len_present     (req_client_len_present),
      .req_client_len             (req_client_len),
      .req_server_len_present     (req_server_len_present),
      .req_server_len             (req_server_len),
      .req_words_present          (req_words_present),
      .req_status_code            (req_status_code),
      .head                       (head),
      .pop                        (pop)
   );

   // chunk end is tracked by remaining bytes: last word when at most one
   // word's worth is left (a zero-length chunk ends on its first word)
   tmarb_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_len_taken    (rsp_len_taken),
      .rsp_word_taken   (rsp_word_taken),
      .rsp_status_taken (rsp_status_taken),
      .rsp_meta_valid   (rsp_meta_valid),
      .rsp_meta_session (rsp_meta_session),
      .rsp_meta_length  (rsp_meta_length),
      .rsp_word_forward (rsp_word_forward),
      .rsp_word_keep    (rsp_word_keep),
      .rsp_word_last    (rsp_word_last)
   );

endmodule
`default_nettype wire

### tb/two_way_tx_merge_arbiter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_way_tx_merge_arbiter_tb
// Self-checking testbench for the two-way transmit merge arbiter.
// ----------------------------------------------------------------------------
// Each request is one tick of the upstream queue heads. A scoreboard class
// keeps its own copy of the session and phase state, predicts the response
// of every accepted request and checks responses in order, field by field.
// A directed opener walks the select / wait / write / discard machine through
// its corner cases. Random ticks then follow the predicted phase, so most
// chunks really get selected, acknowledged and streamed, with noise mixed in.
// Both channels idle at random, with one stretch of steady traffic.
// ----------------------------------------------------------------------------
module two_way_tx_merge_arbiter_tb;
   import tmarb_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int ITEM_TARGET  = 875;   // random part; the opener adds 25
   localparam int TAIL_CYCLES  = 8;

   // One tick of queue heads, as offered on the request channel.
   typedef struct packed {
      logic              srv_p;
      logic [SESS_W-1:0] srv;
      logic              cli_p;
      logic [SESS_W-1:0] cli;
      logic [1:0]        lost;
      logic              clp;
      logic [LEN_W-1:0]  cl;
      logic              slp;
      logic [LEN_W-1:0]  sl;
      logic [1:0]        words;
      status_type        status;
   } heads_t;

   // What the arbiter does with one tick.
   typedef struct packed {
      logic [1:0]        len_taken;
      logic [1:0]        word_taken;
      logic              status_taken;
      logic              meta_valid;
      logic [SESS_W-1:0] meta_session;
      logic [LEN_W-1:0]  meta_length;
      logic              word_forward;
      logic [KEEP_W-1:0] word_keep;
      logic              word_last;
   } tx_action_t;

   // -------------------------------------------------------------------------
   // Scoreboard: shadow state of the arbiter plus the queue of actions that
   // are still owed by the response channel.
   // -------------------------------------------------------------------------
   class tx_merge_scoreboard;
      phase_type         phase;
      logic [SESS_W-1:0] server_id, client_id;
      bit                server_live, client_live;
      bit                favor_client, active_client;
      logic [LEN_W-1:0]  chunk_length, bytes_left;
      logic [10:0]       words_total, words_done;
      tx_action_t        owed[$];
      int                errors;

      function new();
         phase         = PH_SELECT;
         server_id     = '0;
         client_id     = '0;
         server_live   = 0;
         client_live   = 0;
         favor_client  = 0;
         active_client = 0;
         chunk_length  = '0;
         bytes_left    = '0;
         words_total   = '0;
         words_done    = '0;
         errors        = 0;
      endfunction

      function int pending();
         return owed.size();
      endfunction

      function tx_action_t with_meta(tx_action_t a);
         a.meta_valid   = 1'b1;
         a.meta_session = active_client ? client_id : server_id;
         a.meta_length  = chunk_length;
         return a;
      endfunction

      // Chunk done, written or dropped: hand priority to the other side.
      function void close_chunk();
         favor_client = !favor_client;
         phase        = PH_SELECT;
      endfunction

      // Steps the shadow state by one accepted tick and queues the action.
      function void note_request(heads_t h);
         tx_action_t  a;
         bit          c_ok, s_ok, pick, drop, has_word;
         int unsigned n;
         a = '0;
         // updates first, then losses: a loss in the same tick wins
         if (h.srv_p) begin
            server_id   = h.srv;
            server_live = 1;
         end
         if (h.cli_p) begin
            client_id   = h.cli;
            client_live = 1;
         end
         if (h.lost[LOST_CLIENT_BIT]) client_live = 0;
         if (h.lost[LOST_SERVER_BIT]) server_live = 0;
         has_word = h.words[active_client ? WORD_DOWN_BIT : WORD_UP_BIT];
         case (phase)
            PH_SELECT: begin
               c_ok = client_live && h.clp;
               s_ok = server_live && h.slp;
               pick = 0;
               drop = 0;
               if (favor_client ? c_ok : !s_ok && c_ok) begin
                  active_client = 1;
                  pick = 1;
               end else if (s_ok) begin
                  active_client = 0;
                  pick = 1;
               end else if (h.clp && !client_live) begin
                  active_client = 1;
                  drop = 1;
               end else if (h.slp && !server_live) begin
                  active_client = 0;
                  drop = 1;
               end
               if (pick || drop) begin
                  chunk_length = active_client ? h.cl : h.sl;
                  a.len_taken  = active_client ? TAKE_DOWN : TAKE_UP;
                  words_total  = 11'((int'(chunk_length) + WORD_BYTES - 1) / WORD_BYTES);
                  words_done   = '0;
                  bytes_left   = chunk_length;
               end
               if (pick) begin
                  a = with_meta(a);
                  phase = PH_WAIT;
               end else if (drop) begin
                  phase = PH_DISCARD;
               end
            end
            PH_WAIT: begin
               if (h.status != ST_NONE) begin
                  a.status_taken = 1'b1;
                  case (h.status)
                     ST_ACCEPTED: phase = PH_WRITE;
                     ST_CLOSED: begin
                        if (active_client) client_live = 0;
                        else server_live = 0;
                        phase = PH_DISCARD;
                     end
                     default: a = with_meta(a);
                  endcase
               end
            end
            PH_WRITE: begin
               if (has_word) begin
                  n = (int'(bytes_left) >= WORD_BYTES) ? WORD_BYTES : int'(bytes_left);
                  a.word_taken   = active_client ? TAKE_DOWN : TAKE_UP;
                  a.word_forward = 1'b1;
                  a.word_keep    = (n >= KEEP_W) ? '1 : (64'd1 << n) - 64'd1;
                  bytes_left     = bytes_left - LEN_W'(n);
                  words_done     = words_done + 11'd1;
                  if (words_done >= words_total) begin
                     a.word_last = 1'b1;
                     close_chunk();
                  end
               end
            end
            default: begin
               if (has_word) begin
                  a.word_taken = active_client ? TAKE_DOWN : TAKE_UP;
                  words_done   = words_done + 11'd1;
                  if (words_done >= words_total) close_chunk();
               end
            end
         endcase
         owed.push_back(a);
      endfunction

      task report(string what);
         if (errors < 50) $display("%0t: ERROR %s", $time, what);
         errors++;
      endtask

      task cmp_field(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want)
            report($sformatf("%s got %h, expected %h", name, got, want));
      endtask

      task check_response(tx_action_t got);
         tx_action_t want;
         if (owed.size() == 0) begin
            report("response with no request outstanding");
            return;
         end
         want = owed.pop_front();
         cmp_field("len_taken",    64'(got.len_taken),    64'(want.len_taken));
         cmp_field("word_taken",   64'(got.word_taken),   64'(want.word_taken));
         cmp_field("status_taken", 64'(got.status_taken), 64'(want.status_taken));
         cmp_field("meta_valid",   64'(got.meta_valid),   64'(want.meta_valid));
         cmp_field("meta_session", 64'(got.meta_session), 64'(want.meta_session));
         cmp_field("meta_length",  64'(got.meta_length),  64'(want.meta_length));
         cmp_field("word_forward", 64'(got.word_forward), 64'(want.word_forward));
         cmp_field("word_keep",    got.word_keep,         want.word_keep);
         cmp_field("word_last",    64'(got.word_last),    64'(want.word_last));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block signals. Everything starts at a known value.
   // -------------------------------------------------------------------------
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_server_session_present = 1'b0;
   logic [SESS_W-1:0] req_server_session = '0;
   logic              req_client_session_present = 1'b0;
   logic [SESS_W-1:0] req_client_session = '0;
   logic [1:0]        req_lost_flags = '0;
   logic              req_client_len_present = 1'b0;
   logic [LEN_W-1:0]  req_client_len = '0;
   logic              req_server_len_present = 1'b0;
   logic [LEN_W-1:0]  req_server_len = '0;
   logic [1:0]        req_words_present = '0;
   logic [1:0]        req_status_code = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [1:0]        rsp_len_taken;
   logic [1:0]        rsp_word_taken;
   logic              rsp_status_taken;
   logic              rsp_meta_valid;
   logic [SESS_W-1:0] rsp_meta_session;
   logic [LEN_W-1:0]  rsp_meta_length;
   logic              rsp_word_forward;
   logic [KEEP_W-1:0] rsp_word_keep;
   logic              rsp_word_last;

   tx_merge_scoreboard sb;
   bit                 steady = 0;   // no idling on either side while set
   int                 cycle_count = 0;

   two_way_tx_merge_arbiter i_dut (
      .clock                      (clock),
      .reset                      (reset),
      .req_valid                  (req_valid),
      .req_stall                  (req_stall),
      .req_server_session_present (req_server_session_present),
      .req_server_session         (req_server_session),
      .req_client_session_present (req_client_session_present),
      .req_client_session         (req_client_session),
      .req_lost_flags             (req_lost_flags),
      .req_client_len_present     (req_client_len_present),
      .req_client_len             (req_client_len),
      .req_server_len_present     (req_server_len_present),
      .req_server_len             (req_server_len),
      .req_words_present          (req_words_present),
      .req_status_code            (req_status_code),
      .rsp_valid                  (rsp_valid),
      .rsp_stall                  (rsp_stall),
      .rsp_len_taken              (rsp_len_taken),
      .rsp_word_taken             (rsp_word_taken),
      .rsp_status_taken           (rsp_status_taken),
      .rsp_meta_valid             (rsp_meta_valid),
      .rsp_meta_session           (rsp_meta_session),
      .rsp_meta_length            (rsp_meta_length),
      .rsp_word_forward           (rsp_word_forward),
      .rsp_word_keep              (rsp_word_keep),
      .rsp_word_last              (rsp_word_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Idle length: mostly none or short, now and then a long one.
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Chunk length offered at a select tick: mostly short chunks so many of
   // them complete; zero length included, a maximum 65535-byte chunk very rarely.
   function automatic logic [LEN_W-1:0] chunk_size();
      int r;
      r = $urandom_range(0, 999);
      if (r == 0) return '1;
      if (r < 50) return '0;
      if (r < 850) return LEN_W'($urandom_range(1, 300));
      if (r < 990) return LEN_W'($urandom_range(301, 2048));
      return LEN_W'($urandom_range(2049, 8192));
   endfunction

   function automatic heads_t mk(int srv_p, int srv, int cli_p, int cli, int lost,
                                 int clp, int cl, int slp, int sl, int words,
                                 status_type status);
      heads_t h;
      h.srv_p  = 1'(srv_p);
      h.srv    = SESS_W'(srv);
      h.cli_p  = 1'(cli_p);
      h.cli    = SESS_W'(cli);
      h.lost   = 2'(lost);
      h.clp    = 1'(clp);
      h.cl     = LEN_W'(cl);
      h.slp    = 1'(slp);
      h.sl     = LEN_W'(sl);
      h.words  = 2'(words);
      h.status = status;
      return h;
   endfunction

   // Random tick shaped by the predicted phase: lengths are sane when they
   // can be popped, status is mostly meaningful while waiting, and the
   // active direction mostly has a word ready while streaming or dropping.
   function automatic heads_t random_heads();
      heads_t      h;
      logic [95:0] noise;
      int          r;
      noise = {$urandom, $urandom, $urandom};
      if ($urandom_range(0, 99) < 8) return heads_t'(noise[$bits(heads_t)-1:0]);
      h.srv_p = ($urandom_range(0, 99) < (sb.server_live ? 3 : 25));
      h.srv   = SESS_W'($urandom);
      h.cli_p = ($urandom_range(0, 99) < (sb.client_live ? 3 : 25));
      h.cli   = SESS_W'($urandom);
      h.lost[LOST_CLIENT_BIT] = ($urandom_range(0, 99) < 3);
      h.lost[LOST_SERVER_BIT] = ($urandom_range(0, 99) < 3);
      h.clp   = ($urandom_range(0, 99) < 70);
      h.slp   = ($urandom_range(0, 99) < 70);
      if (sb.phase == PH_SELECT) begin
         h.cl = chunk_size();
         h.sl = chunk_size();
      end else begin
         h.cl = LEN_W'($urandom);
         h.sl = LEN_W'($urandom);
      end
      h.words = 2'($urandom);
      if ((sb.phase == PH_WRITE || sb.phase == PH_DISCARD) && $urandom_range(0, 99) < 75)
         h.words[sb.active_client ? WORD_DOWN_BIT : WORD_UP_BIT] = 1'b1;
      if (sb.phase == PH_WAIT) begin
         r = $urandom_range(0, 99);
         h.status = (r < 60) ? ST_ACCEPTED :
                    (r < 80) ? ST_NO_SPACE :
                    (r < 88) ? ST_CLOSED : ST_NONE;
      end else begin
         h.status = status_type'($urandom_range(0, 3));
      end
      return h;
   endfunction

   // Offers one tick and holds it until accepted.
   task automatic send_request(input heads_t h);
      req_valid                  <= 1'b1;
      req_server_session_present <= h.srv_p;
      req_server_session         <= h.srv;
      req_client_session_present <= h.cli_p;
      req_client_session         <= h.cli;
      req_lost_flags             <= h.lost;
      req_client_len_present     <= h.clp;
      req_client_len             <= h.cl;
      req_server_len_present     <= h.slp;
      req_server_len             <= h.sl;
      req_words_present          <= h.words;
      req_status_code            <= h.status;
      do @(posedge clock); while (req_stall);
      sb.note_request(h);
   endtask

   // Random gap after a request (none during the steady stretch).
   task automatic sender_gap();
      int n;
      n = steady ? 0 : idle_len();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Stop sending until every owed response has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Response side: check at each handshake, then pick the next stall.
   // -------------------------------------------------------------------------
   initial begin
      int         stall_left;
      tx_action_t got;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.len_taken    = rsp_len_taken;
            got.word_taken   = rsp_word_taken;
            got.status_taken = rsp_status_taken;
            got.meta_valid   = rsp_meta_valid;
            got.meta_session = rsp_meta_session;
            got.meta_length  = rsp_meta_length;
            got.word_forward = rsp_word_forward;
            got.word_keep    = rsp_word_keep;
            got.word_last    = rsp_word_last;
            sb.check_response(got);
         end
         if (stall_left == 0 && !steady) stall_left = idle_len();
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      heads_t opener[$];
      int     item_count;
      bit     paused;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // idle select tick
      opener.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_NONE));
      // both sessions come up; uplink favored first; status and words are
      // ignored outside their phases
      opener.push_back(mk(1, 'hFFFF, 1, 0, 0, 1, 1, 1, 65, 3, ST_ACCEPTED));
      opener.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 3, ST_NONE));
      // no space: meta again, then again after the session id changed
      opener.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_NO_SPACE));
      opener.push_back(mk(1, 'h1234, 0, 0, 0, 0, 0, 0, 0, 0, ST_NO_SPACE));
      opener.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_ACCEPTED));
      // word of the other direction ignored; full word, then a one-byte tail
      opener.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_NONE));
      opener.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 2, ST_NONE));
      opener.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 2, ST_NONE));
      // downlink now favored, zero-length chunk: keep empty, last set
      opener.push_back(mk(0, 0, 0, 0, 0, 1, 0, 1, 10, 0, ST_NONE));
      opener.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_ACCEPTED));
      opener.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_NONE));
      // uplink again; connection closed -> session dead, words dropped
      opener.push_back(mk(0, 0, 0, 0, 0, 1, 5, 1, 200, 0, ST_NONE));
      opener.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_CLOSED));
      opener.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 2, ST_NONE));
      // update and loss in one tick: loss wins on both sides
      opener.push_back(mk(1, 'h00FF, 1, 'hAAAA, 3, 0, 0, 0, 0, 2, ST_ACCEPTED));
      opener.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 2, ST_NONE));
      opener.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 3, ST_NONE));
      // both dead with lengths pending: downlink dropped first, then uplink
      opener.push_back(mk(0, 0, 0, 0, 0, 1, 64, 1, 64, 0, ST_NONE));
      opener.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_NONE));
      opener.push_back(mk(0, 0, 0, 0, 0, 0, 0, 1, 128, 0, ST_NONE));
      opener.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 2, ST_NONE));
      opener.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 2, ST_NONE));
      // sessions back with extreme ids
      opener.push_back(mk(1, 0, 1, 'hFFFF, 0, 1, 64, 1, 64, 0, ST_NONE));
      opener.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_ACCEPTED));

      foreach (opener[i]) begin
         send_request(opener[i]);
         sender_gap();
      end
      drain();

      // Random part; a stretch in the middle runs with no idling, and the
      // sender holds off once until the response side is empty.
      item_count = 0;
      paused     = 0;
      while (item_count < ITEM_TARGET) begin
         steady = (item_count >= 400 && item_count < 550);
         send_request(random_heads());
         item_count++;
         if (!paused && item_count >= 600) begin
            paused = 1;
            drain();
         end else begin
            sender_gap();
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
